// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the reorder buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, held off while rst_ni is low.
`define RBTF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("reorder buffer check failed");

`endif

// ----- rtl/rbtf_pkg.sv -----
// Package with sizes, operation codes, entry type and pointer helper of the reorder buffer.
package rbtf_pkg;

  localparam int ROB_DEPTH = 16;
  localparam int PTR_W     = $clog2(ROB_DEPTH);
  localparam int CNT_W     = $clog2(ROB_DEPTH + 1);
  localparam int STAMP_W   = 32;
  localparam int REG_W     = 6;
  localparam int FUNC_W    = 2;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COMMIT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MATCH  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd3;

  // One buffer entry.
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [REG_W-1:0]   dest;
    logic               writes;
  } entry_t;

  // Slot that lies off places behind ptr, wrapping at the buffer depth.
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                               input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(ROB_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(ROB_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// ----- rtl/rbtf_cmp.sv -----
// Shared timestamp compare unit used by match and by the flush scan.
module rbtf_cmp import rbtf_pkg::*; (
  input  logic [STAMP_W-1:0] entry_stamp_i,
  input  logic [STAMP_W-1:0] query_stamp_i,
  output logic               eq_o,
  output logic               lt_o
);

  // Unsigned compare of the stored stamp against the query stamp.
  assign eq_o = (entry_stamp_i == query_stamp_i);
  assign lt_o = (entry_stamp_i < query_stamp_i);

endmodule

// ----- rtl/rbtf_mem.sv -----
// Entry storage of the reorder buffer: one write port and one registered read port.
module rbtf_mem import rbtf_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [PTR_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [PTR_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [ROB_DEPTH];
  entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/reorder_buffer_timestamp_flush.sv -----
// Top level of the reorder buffer with timestamp flush.
// In-order queue of ROB_DEPTH entries (stamp, destination, writes flag) kept in one memory
// with a registered read port and served by one shared stamp comparator. An operation is
// taken when in_ready_o is high. For allocate, commit and match the result is loaded into
// the output register as the block leaves its execute state, and the block is then ready
// again. A flush walks the buffer from the head through the memory read port and
// comparator, one entry a cycle, and keeps the entries ahead of the first one whose stamp
// is not older than the flush stamp. While the output register holds a result that has
// not been taken, the next operation waits in its last step. The block takes a new
// operation as soon as the previous one has moved its result into the output register,
// even if that result is still waiting.
module reorder_buffer_timestamp_flush import rbtf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FUNC_W-1:0]  func_i,
  input  logic [STAMP_W-1:0] stamp_i,
  input  logic               writes_reg_i,
  input  logic [REG_W-1:0]   dest_reg_i,
  input  logic               query_valid_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               accepted_o,
  output logic               commit_valid_o,
  output logic [REG_W-1:0]   commit_reg_o,
  output logic               matched_o,
  output logic               empty_res_o,
  output logic [CNT_W-1:0]   occupancy_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic               state_q, state_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]   scan_q, scan_d;

  // Operation held while it executes.
  logic [FUNC_W-1:0]  func_q;
  logic [STAMP_W-1:0] stamp_q;
  logic               writes_q;
  logic [REG_W-1:0]   dest_q;
  logic               qvalid_q;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic               acc_q, acc_d;
  logic               cvalid_q, cvalid_d;
  logic [REG_W-1:0]   creg_q, creg_d;
  logic               match_q, match_d;

  logic               in_xfer;
  logic               slot_free;
  logic               scan_go;
  logic               finish;
  logic               mem_we;
  logic [PTR_W-1:0]   rd_addr;
  entry_t             wr_entry;
  entry_t             rd_entry;
  logic               cmp_eq;
  logic               cmp_lt;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // Flush keeps walking while the entry under the read port is older than the boundary.
  assign scan_go = (state_q == S_EXEC) && (func_q == FUNC_FLUSH) && (scan_q < fill_q) &&
                   cmp_lt;
  assign finish  = (state_q == S_EXEC) && !scan_go && slot_free;
  assign rd_addr = ptr_add(head_q, scan_go ? scan_q + CNT_W'(1) : scan_q);

  assign mem_we   = finish && (func_q == FUNC_ALLOC) && (fill_q < CNT_W'(ROB_DEPTH));
  assign wr_entry = '{stamp: stamp_q, dest: dest_q, writes: writes_q};

  rbtf_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail_q),
    .wdata_i (wr_entry),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  rbtf_cmp u_cmp (
    .entry_stamp_i (rd_entry.stamp),
    .query_stamp_i (stamp_q),
    .eq_o          (cmp_eq),
    .lt_o          (cmp_lt)
  );

  // Sequencer and result generation.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    scan_d      = scan_q;
    out_valid_d = out_valid_q && !out_ready_i;
    acc_d       = acc_q;
    cvalid_d    = cvalid_q;
    creg_d      = creg_q;
    match_d     = match_q;

    if (in_xfer) begin
      state_d = S_EXEC;
    end
    if (scan_go) begin
      scan_d = scan_q + CNT_W'(1);
    end
    if (finish) begin
      state_d     = S_IDLE;
      scan_d      = '0;
      out_valid_d = 1'b1;
      acc_d       = 1'b0;
      cvalid_d    = 1'b0;
      creg_d      = '0;
      match_d     = 1'b0;
      case (func_q)
        FUNC_ALLOC: begin
          if (fill_q < CNT_W'(ROB_DEPTH)) begin
            tail_d = ptr_add(tail_q, CNT_W'(1));
            fill_d = fill_q + CNT_W'(1);
            acc_d  = 1'b1;
          end
        end
        FUNC_COMMIT: begin
          if (fill_q != '0) begin
            cvalid_d = rd_entry.writes;
            creg_d   = rd_entry.writes ? rd_entry.dest : '0;
            head_d   = ptr_add(head_q, CNT_W'(1));
            fill_d   = fill_q - CNT_W'(1);
          end
        end
        FUNC_MATCH: begin
          match_d = qvalid_q && (fill_q != '0) && cmp_eq;
        end
        FUNC_FLUSH: begin
          fill_d = scan_q;
          tail_d = ptr_add(head_q, scan_q);
        end
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Operation capture on an input transfer.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q   <= func_i;
      stamp_q  <= stamp_i;
      writes_q <= writes_reg_i;
      dest_q   <= dest_reg_i;
      qvalid_q <= query_valid_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    cvalid_q <= cvalid_d;
    creg_q   <= creg_d;
    match_q  <= match_d;
  end

  // Occupancy after the step is the fill count once the result is loaded.
  logic [CNT_W-1:0] occ_q;
  always_ff @(posedge clk_i) begin
    if (finish) begin
      occ_q <= fill_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = acc_q;
  assign commit_valid_o = cvalid_q;
  assign commit_reg_o   = creg_q;
  assign matched_o      = match_q;
  assign occupancy_o    = occ_q;
  assign empty_res_o    = (occ_q == '0);

endmodule

// ----- rtl/rbtf_checker.sv -----
// Port-level checker of the reorder buffer and its bind to the top level.
`include "assert_macros.svh"

module rbtf_checker import rbtf_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [FUNC_W-1:0]  func_i,
  input logic [STAMP_W-1:0] stamp_i,
  input logic               writes_reg_i,
  input logic [REG_W-1:0]   dest_reg_i,
  input logic               query_valid_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               accepted_o,
  input logic               commit_valid_o,
  input logic [REG_W-1:0]   commit_reg_o,
  input logic               matched_o,
  input logic               empty_res_o,
  input logic [CNT_W-1:0]   occupancy_o
);

  logic [2:0] flags;
  assign flags = {accepted_o, commit_valid_o, matched_o};

  // A stalled result keeps its occupancy.
  `RBTF_ASSERT(a_stall_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(occupancy_o))
  // Empty flag agrees with the occupancy count.
  `RBTF_ASSERT(a_empty_cnt, out_valid_o |-> (empty_res_o == (occupancy_o == '0)))
  // Occupancy never exceeds the depth.
  `RBTF_ASSERT(a_occ_max, out_valid_o |-> (occupancy_o <= CNT_W'(ROB_DEPTH)))
  // One operation reports at most one success flag.
  `RBTF_ASSERT(a_one_flag, out_valid_o |-> $onehot0(flags))
  // A commit without a register write hands out register zero.
  `RBTF_ASSERT(a_creg_zero, out_valid_o && !commit_valid_o |-> (commit_reg_o == '0))

endmodule

bind reorder_buffer_timestamp_flush rbtf_checker u_rbtf_checker (.*);
